[rtl/core/ssu_pkg.sv]
// Shared types, codes and constants for the stride scheduler.
package ssu_pkg;

  localparam int FUNC_W    = 2;
  localparam int SLOT_FW   = 5;
  localparam int PRIO_W    = 16;
  localparam int SLICE_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int COUNT_FW  = 6;
  // Quotient bits of 0x7fffffff / priority
  localparam int DIV_STEPS = 31;

  localparam logic [SLICE_W-1:0] MAX_SLICE_RESET = 8'd5;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_PICK = 2'd2,
    FN_TICK = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK    = 2'd0,
    RES_EMPTY = 2'd1,
    RES_BAD   = 2'd2
  } res_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_CHOOSE,
    S_PICK_WR,
    S_DIV,
    S_ENQ_WR,
    S_TICK_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic      load;
    logic      code_wr;
    res_code_t code;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      scan_rd;
    logic      div_step;
    logic      rd_slice;
    logic      rd_step;
    logic      wr_enq;
    logic      wr_deq;
    logic      wr_tick;
    logic      wr_pick;
    logic      res_load;
  } ssu_cmd_t;

  typedef struct packed {
    func_t func;
    logic  bad;
    logic  found;
    logic  last_scan;
    logic  last_div;
    logic  out_free;
  } ssu_stat_t;

endpackage

[rtl/core/ssu_ctrl.sv]
// Request sequencer: decodes a request and steps the datapath through it.
module ssu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssu_pkg::ssu_stat_t stat,
  output ssu_pkg::ssu_cmd_t  cmd
);
  import ssu_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.code_wr = 1'b1;
        if (stat.bad) begin
          cmd.code   = RES_BAD;
          state_next = S_FINISH;
        end else begin
          cmd.code = RES_OK;
          unique case (stat.func)
            FN_ENQ: begin
              cmd.cnt_clr = 1'b1;
              state_next  = S_DIV;
            end
            FN_DEQ: begin
              cmd.wr_deq = 1'b1;
              state_next = S_FINISH;
            end
            FN_TICK: begin
              cmd.rd_slice = 1'b1;
              state_next   = S_TICK_WR;
            end
            FN_PICK: begin
              cmd.cnt_clr = 1'b1;
              state_next  = S_SCAN;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.last_scan) begin
          state_next = S_DRAIN;
        end
      end
      // last compare lands at the end of this cycle
      S_DRAIN: state_next = S_CHOOSE;
      S_CHOOSE: begin
        if (stat.found) begin
          cmd.rd_step = 1'b1;
          state_next  = S_PICK_WR;
        end else begin
          cmd.code_wr = 1'b1;
          cmd.code    = RES_EMPTY;
          state_next  = S_FINISH;
        end
      end
      S_PICK_WR: begin
        cmd.wr_pick = 1'b1;
        state_next  = S_FINISH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (stat.last_div) begin
          state_next = S_ENQ_WR;
        end
      end
      S_ENQ_WR: begin
        cmd.wr_enq = 1'b1;
        state_next = S_FINISH;
      end
      S_TICK_WR: begin
        cmd.wr_tick = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/core/ssu_dpath.sv]
// Slot tables, pass scan, stride divider and result register.
module ssu_dpath #(
  parameter int SLOTS     = 32,
  parameter int PASS_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ssu_pkg::ssu_cmd_t               cmd,
  output ssu_pkg::ssu_stat_t              stat,
  input  logic [ssu_pkg::FUNC_W-1:0]      func,
  input  logic [ssu_pkg::SLOT_FW-1:0]     task_slot,
  input  logic [ssu_pkg::PRIO_W-1:0]      task_priority,
  input  logic [ssu_pkg::SLICE_W-1:0]     slice_given,
  input  logic                            cfg_wr_en,
  input  logic [ssu_pkg::SLICE_W-1:0]     cfg_wr_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ssu_pkg::STATUS_W-1:0]    status,
  output logic [ssu_pkg::SLOT_FW-1:0]     picked_slot,
  output logic                            resched_flag,
  output logic [ssu_pkg::COUNT_FW-1:0]    queued_count
);
  import ssu_pkg::*;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int SEQ_MAX = (SLOTS > DIV_STEPS) ? SLOTS : DIV_STEPS;
  localparam int SEQ_W   = $clog2(SEQ_MAX);
  localparam int STEP_W  = DIV_STEPS;

  // request beat
  func_t              req_func;
  logic [SLOT_FW-1:0] req_slot;
  logic [PRIO_W-1:0]  req_prio;
  logic [SLICE_W-1:0] req_given;
  logic [SLICE_W-1:0] max_slice;

  logic [SLOT_W-1:0]  slot_idx;
  logic               slot_oob;
  logic               req_bad;

  logic [SEQ_W-1:0]   seq_cnt;
  logic [SLOT_W-1:0]  scan_idx;

  logic [SLOTS-1:0]   runnable;
  logic [SLOTS-1:0]   pass_vld;
  logic [SLOTS-1:0]   slice_vld;
  logic [CNT_W-1:0]   count;

  logic [PASS_BITS-1:0] pass_mem [SLOTS];
  logic [STEP_W-1:0]    step_mem [SLOTS];
  logic [SLICE_W-1:0]   slice_mem [SLOTS];
  logic [PASS_BITS-1:0] pass_q;
  logic [STEP_W-1:0]    step_q;
  logic [SLICE_W-1:0]   slice_q;

  logic                 cmp_en;
  logic [SLOT_W-1:0]    cmp_idx;
  logic [PASS_BITS-1:0] cmp_pass;
  logic [PASS_BITS-1:0] cmp_diff;
  logic                 take;
  logic                 found;
  logic [SLOT_W-1:0]    best;
  logic [PASS_BITS-1:0] best_pass;
  logic [PASS_BITS-1:0] pass_sum;

  logic [PRIO_W-1:0]  dvs;
  logic [PRIO_W-1:0]  rem;
  logic [STEP_W-1:0]  quo;
  logic [PRIO_W:0]    trial;
  logic [PRIO_W:0]    trial_sub;
  logic               fits;

  logic [SLICE_W-1:0] enq_slice;
  logic [SLICE_W-1:0] tick_cur;
  logic [SLICE_W-1:0] tick_next;
  logic               tick_zero;
  res_code_t          res_code;
  logic               out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func  <= func_t'(func);
      req_slot  <= task_slot;
      req_prio  <= task_priority;
      req_given <= slice_given;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_slice <= MAX_SLICE_RESET;
    end else if (cfg_wr_en) begin
      max_slice <= cfg_wr_data;
    end
  end

  assign slot_idx = SLOT_W'(req_slot);
  assign slot_oob = 32'(req_slot) >= SLOTS;

  always_comb begin
    unique case (req_func)
      FN_ENQ:  req_bad = slot_oob || runnable[slot_idx];
      FN_DEQ:  req_bad = slot_oob || !runnable[slot_idx];
      FN_TICK: req_bad = slot_oob;
      FN_PICK: req_bad = 1'b0;
      default: req_bad = 1'b1;
    endcase
  end

  // shared sequence counter: scan index or divide step
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_cnt <= '0;
    end else if (cmd.cnt_clr) begin
      seq_cnt <= '0;
    end else if (cmd.cnt_inc) begin
      seq_cnt <= seq_cnt + SEQ_W'(1);
    end
  end

  assign scan_idx = seq_cnt[SLOT_W-1:0];

  // pass table
  always_ff @(posedge clk) begin
    if (cmd.wr_pick) begin
      pass_mem[best] <= pass_sum;
    end
    if (cmd.scan_rd) begin
      pass_q <= pass_mem[scan_idx];
    end
  end

  // stride table
  always_ff @(posedge clk) begin
    if (cmd.wr_enq) begin
      step_mem[slot_idx] <= quo;
    end
    if (cmd.rd_step) begin
      step_q <= step_mem[best];
    end
  end

  // slice table
  always_ff @(posedge clk) begin
    if (cmd.wr_enq) begin
      slice_mem[slot_idx] <= enq_slice;
    end else if (cmd.wr_tick) begin
      slice_mem[slot_idx] <= tick_next;
    end
    if (cmd.rd_slice) begin
      slice_q <= slice_mem[slot_idx];
    end
  end

  // compare stage, one slot behind the table read
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
  end

  assign cmp_pass = pass_vld[cmp_idx] ? pass_q : '0;
  assign cmp_diff = cmp_pass - best_pass;
  // strict less keeps the lowest slot on ties
  assign take     = cmp_en && runnable[cmp_idx] && (!found || cmp_diff[PASS_BITS-1]);
  assign pass_sum = best_pass + PASS_BITS'(step_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.cnt_clr) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best      <= cmp_idx;
      best_pass <= cmp_pass;
    end
  end

  // restoring divider; the dividend is all ones, so each step shifts in a one
  assign dvs       = (req_prio == '0) ? PRIO_W'(1) : req_prio;
  assign trial     = {rem, 1'b1};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= fits ? trial_sub[PRIO_W-1:0] : trial[PRIO_W-1:0];
      quo <= {quo[STEP_W-2:0], fits};
    end
  end

  assign enq_slice = (req_given == '0 || req_given > max_slice) ? max_slice : req_given;
  assign tick_cur  = slice_vld[slot_idx] ? slice_q : '0;
  assign tick_next = tick_cur - SLICE_W'(tick_cur != '0);

  always_ff @(posedge clk) begin
    if (cmd.wr_tick) begin
      tick_zero <= (tick_next == '0);
    end
    if (cmd.code_wr) begin
      res_code <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      runnable  <= '0;
      pass_vld  <= '0;
      slice_vld <= '0;
      count     <= '0;
    end else begin
      if (cmd.wr_enq) begin
        runnable[slot_idx]  <= 1'b1;
        slice_vld[slot_idx] <= 1'b1;
        count               <= count + CNT_W'(1);
      end else if (cmd.wr_deq) begin
        runnable[slot_idx] <= 1'b0;
        count              <= count - CNT_W'(1);
      end else if (cmd.wr_tick) begin
        slice_vld[slot_idx] <= 1'b1;
      end
      if (cmd.wr_pick) begin
        pass_vld[best] <= 1'b1;
      end
    end
  end

  // result register: the next request may start while this beat waits
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status       <= res_code;
      picked_slot  <= (res_code == RES_OK && req_func == FN_PICK) ? SLOT_FW'(best) : '0;
      resched_flag <= (res_code == RES_OK && req_func == FN_TICK) ? tick_zero : 1'b0;
      queued_count <= COUNT_FW'(count);
    end
  end

  always_comb begin
    stat.func      = req_func;
    stat.bad       = req_bad;
    stat.found     = found;
    stat.last_scan = (seq_cnt == SEQ_W'(SLOTS - 1));
    stat.last_div  = (seq_cnt == SEQ_W'(DIV_STEPS - 1));
    stat.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_count_matches : assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(runnable)))
    else $error("runnable count out of step with runnable bits");

  a_load_free : assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> out_free)
    else $error("result loaded over an undelivered beat");

  a_pick_found : assert property (@(posedge clk) disable iff (rst)
    cmd.wr_pick |-> found)
    else $error("pass update without a chosen slot");

  a_enq_idle : assert property (@(posedge clk) disable iff (rst)
    cmd.wr_enq |-> (!runnable[slot_idx] && !slot_oob))
    else $error("enqueue committed on a runnable or missing slot");
`endif

endmodule

[rtl/core/stride_scheduler_unit.sv]
// Stride scheduler top level: one result beat per request beat.
// Enqueue runs a 31-step stride divide; pick scans every slot, then updates the
// winner's pass unless the table is empty; tick, dequeue and bad requests skip both.
// Throughput: one request at a time; the next is taken once the result sits
// in the output register, which holds it while out_stall is high.
// Reset (rst, synchronous): all slots idle, pass and slice read as zero, slice bound 5.
module stride_scheduler_unit #(
  parameter int SLOTS     = 32,
  parameter int PASS_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ssu_pkg::FUNC_W-1:0]      func,
  input  logic [ssu_pkg::SLOT_FW-1:0]     task_slot,
  input  logic [ssu_pkg::PRIO_W-1:0]      task_priority,
  input  logic [ssu_pkg::SLICE_W-1:0]     slice_given,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ssu_pkg::STATUS_W-1:0]    status,
  output logic [ssu_pkg::SLOT_FW-1:0]     picked_slot,
  output logic                            resched_flag,
  output logic [ssu_pkg::COUNT_FW-1:0]    queued_count,
  input  logic                            cfg_wr_en,
  input  logic [ssu_pkg::SLICE_W-1:0]     cfg_wr_data
);
  import ssu_pkg::*;

  ssu_cmd_t  cmd;
  ssu_stat_t stat;
  logic      in_ready;

  assign in_stall = !in_ready;

  ssu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssu_dpath #(
    .SLOTS     (SLOTS),
    .PASS_BITS (PASS_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .func          (func),
    .task_slot     (task_slot),
    .task_priority (task_priority),
    .slice_given   (slice_given),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .picked_slot   (picked_slot),
    .resched_flag  (resched_flag),
    .queued_count  (queued_count)
  );

endmodule

[sim/stride_scheduler_unit_test.sv]
// Self-checking testbench for the stride scheduler unit with a predicting scoreboard.
`timescale 1ns / 1ps

module stride_scheduler_unit_test;
  import ssu_pkg::*;

  typedef struct {
    res_code_t          status;
    logic [SLOT_FW-1:0] slot;
    logic               resched;
    logic [COUNT_FW-1:0] count;
  } sched_reply_t;

  class stride_scoreboard;
    logic [31:0]        pass_tbl [32];
    logic [PRIO_W-1:0]  weight_tbl [32];
    logic [SLICE_W-1:0] slice_tbl [32];
    bit                 queued_tbl [32];
    int unsigned        queued_num;
    logic [SLICE_W-1:0] slice_cap;
    sched_reply_t       pending [$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        op_seen [4];
    int unsigned        bad_seen;
    int unsigned        empty_seen;

    function new();
      for (int i = 0; i < 32; i++) begin
        pass_tbl[i] = '0;
        weight_tbl[i] = '0;
        slice_tbl[i] = '0;
        queued_tbl[i] = 1'b0;
      end
      queued_num = 0;
      slice_cap = MAX_SLICE_RESET;
      errors = 0;
      checked = 0;
      bad_seen = 0;
      empty_seen = 0;
      for (int i = 0; i < 4; i++) op_seen[i] = 0;
    endfunction

    // Random slot whose queued mark matches, or -1 if none.
    function int find_slot(bit want_queued);
      int start;
      int s;
      start = $urandom_range(31);
      for (int k = 0; k < 32; k++) begin
        s = (start + k) % 32;
        if (queued_tbl[s] == want_queued) return s;
      end
      return -1;
    endfunction

    function void note_request(func_t fn, logic [SLOT_FW-1:0] slot,
                               logic [PRIO_W-1:0] prio, logic [SLICE_W-1:0] given);
      sched_reply_t r;
      int best;
      logic [31:0] gap;
      logic [31:0] weight;
      r.status = RES_OK;
      r.slot = '0;
      r.resched = 1'b0;
      op_seen[fn]++;
      case (fn)
        FN_PICK: begin
          best = -1;
          // Ascending scan; a later slot wins only when strictly less.
          for (int i = 0; i < 32; i++) begin
            if (queued_tbl[i]) begin
              if (best < 0) begin
                best = i;
              end else begin
                gap = pass_tbl[i] - pass_tbl[best];
                if (gap[31]) best = i;
              end
            end
          end
          if (best < 0) begin
            r.status = RES_EMPTY;
          end else begin
            weight = (weight_tbl[best] == '0) ? 32'd1 : {16'd0, weight_tbl[best]};
            pass_tbl[best] = pass_tbl[best] + 32'h7fffffff / weight;
            r.slot = 5'(best);
          end
        end
        FN_ENQ: begin
          if (queued_tbl[slot]) begin
            r.status = RES_BAD;
          end else begin
            slice_tbl[slot] = (given == '0 || given > slice_cap) ? slice_cap : given;
            weight_tbl[slot] = prio;
            queued_tbl[slot] = 1'b1;
            queued_num++;
          end
        end
        FN_DEQ: begin
          if (!queued_tbl[slot]) begin
            r.status = RES_BAD;
          end else begin
            queued_tbl[slot] = 1'b0;
            queued_num--;
          end
        end
        FN_TICK: begin
          if (slice_tbl[slot] != '0) slice_tbl[slot] = slice_tbl[slot] - 1'b1;
          if (slice_tbl[slot] == '0) r.resched = 1'b1;
        end
      endcase
      if (r.status == RES_BAD) bad_seen++;
      if (r.status == RES_EMPTY) empty_seen++;
      r.count = 6'(queued_num);
      pending.push_back(r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] st, logic [SLOT_FW-1:0] ps,
                              logic nr, logic [COUNT_FW-1:0] qc);
      sched_reply_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected reply beat: status=%0d slot=%0d resched=%0b count=%0d",
                   st, ps, nr, qc);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (st !== e.status || ps !== e.slot || nr !== e.resched || qc !== e.count) begin
        errors++;
        if (errors <= 10) begin
          $display("reply %0d mismatch: exp status=%0d slot=%0d resched=%0b count=%0d",
                   checked, e.status, e.slot, e.resched, e.count);
          $display("  got status=%0d slot=%0d resched=%0b count=%0d", st, ps, nr, qc);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func = '0;
  logic [SLOT_FW-1:0]  task_slot = '0;
  logic [PRIO_W-1:0]   task_priority = '0;
  logic [SLICE_W-1:0]  slice_given = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_FW-1:0]  picked_slot;
  logic                resched_flag;
  logic [COUNT_FW-1:0] queued_count;
  logic                cfg_wr_en = 1'b0;
  logic [SLICE_W-1:0]  cfg_wr_data = '0;

  stride_scoreboard sb;
  bit calm = 1'b0;

  stride_scheduler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .task_slot    (task_slot),
    .task_priority(task_priority),
    .slice_given  (slice_given),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .picked_slot  (picked_slot),
    .resched_flag (resched_flag),
    .queued_count (queued_count),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall = !calm && ($urandom_range(99) < 33);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_reply(status, picked_slot, resched_flag, queued_count);
  end

  // Present one request beat, hold it until taken, and log it with the scoreboard.
  task automatic send_request(func_t fn, logic [SLOT_FW-1:0] slot,
                              logic [PRIO_W-1:0] prio, logic [SLICE_W-1:0] given);
    int gap;
    gap = (!calm && $urandom_range(99) < 33) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func = fn;
    task_slot = slot;
    task_priority = prio;
    slice_given = given;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(fn, slot, prio, given);
  endtask

  // Write the slice bound once all replies are back.
  task automatic write_slice_cap(logic [SLICE_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.slice_cap = value;
  endtask

  task automatic random_request();
    int r;
    int s;
    func_t fn;
    logic [PRIO_W-1:0] prio;
    logic [SLICE_W-1:0] given;
    r = $urandom_range(99);
    s = -1;
    if (r < 27) begin
      fn = FN_ENQ;
      if ($urandom_range(99) < 80) s = sb.find_slot(1'b0);
    end else if (r < 47) begin
      fn = FN_DEQ;
      if ($urandom_range(99) < 85) s = sb.find_slot(1'b1);
    end else if (r < 82) begin
      fn = FN_PICK;
    end else begin
      fn = FN_TICK;
      if ($urandom_range(99) < 70) s = sb.find_slot(1'b1);
    end
    if (s < 0) s = $urandom_range(31);
    // Low priorities make big strides, so passes wrap and orders go cyclic.
    r = $urandom_range(99);
    if (r < 40) prio = 16'($urandom_range(1, 4));
    else if (r < 50) prio = '0;
    else prio = 16'($urandom_range(65535));
    given = ($urandom_range(99) < 20) ? 8'd0 : 8'($urandom_range(255));
    send_request(fn, 5'(s), prio, given);
  endtask

  initial begin
    logic [SLICE_W-1:0] caps [5];
    sb = new();
    caps[0] = 8'd255;
    caps[1] = 8'd1;
    caps[2] = 8'd0;
    caps[3] = 8'($urandom_range(2, 254));
    caps[4] = MAX_SLICE_RESET;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed: empty table, bad requests, slice clamping, tick to zero, pass kept.
    send_request(FN_PICK, 5'd9, 16'h0000, 8'd0);
    send_request(FN_TICK, 5'd7, 16'h0000, 8'd0);
    send_request(FN_DEQ, 5'd3, 16'h0000, 8'd0);
    send_request(FN_ENQ, 5'd0, 16'h0000, 8'd0);
    send_request(FN_ENQ, 5'd31, 16'hffff, 8'd255);
    send_request(FN_ENQ, 5'd0, 16'h0001, 8'd2);
    send_request(FN_ENQ, 5'd5, 16'h0001, 8'd3);
    send_request(FN_ENQ, 5'd10, 16'haaaa, 8'haa);
    send_request(FN_ENQ, 5'd21, 16'h5555, 8'h55);
    repeat (5) send_request(FN_PICK, 5'd0, 16'h0000, 8'd0);
    repeat (4) send_request(FN_TICK, 5'd5, 16'h0000, 8'd0);
    send_request(FN_DEQ, 5'd0, 16'h0000, 8'd0);
    send_request(FN_ENQ, 5'd0, 16'h0002, 8'd1);
    repeat (2) send_request(FN_PICK, 5'd0, 16'h0000, 8'd0);
    send_request(FN_DEQ, 5'd31, 16'h0000, 8'd0);

    for (int p = 0; p < 5; p++) begin
      write_slice_cap(caps[p]);
      calm = (p == 1);
      repeat (220) random_request();
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d enqueues, %0d dequeues, %0d picks, %0d ticks; %0d replies checked",
             sb.op_seen[FN_ENQ], sb.op_seen[FN_DEQ], sb.op_seen[FN_PICK],
             sb.op_seen[FN_TICK], sb.checked);
    $display("%0d bad requests, %0d empty picks, slice bounds 255, 1, 0, %0d and 5; %0d errors",
             sb.bad_seen, sb.empty_seen, caps[3], sb.errors);
    if (sb.errors == 0) begin
      $display("stride_scheduler_unit_test: clean");
    end else begin
      $display("stride_scheduler_unit_test: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout waiting on the scheduler");
    $display("stride_scheduler_unit_test: errors");
    $finish;
  end

endmodule
